/* design/mcr_pkg.sv */
// shared types and constants of the telemetry chunk reassembler
package mcr_pkg;

    localparam int unsigned REQ_BUF_BYTES = 128;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] JUMBO_SIZE = 8'hff;
    localparam logic [7:0] INDEX_MAX  = 8'hff;
    localparam logic [1:0] VER_V1     = 2'd1;
    localparam logic [1:0] VER_MAX    = 2'd2;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_EEPROM_WRITE_CMD = 1'b0,
        CFG_SKIP_VALUE       = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_DISCARD   = 3'd0,
        MODE_STATUS    = 3'd1,
        MODE_HDR_V1    = 3'd2,
        MODE_HDR_JUMBO = 3'd3,
        MODE_HDR_V2    = 3'd4,
        MODE_PAYLOAD   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        EV_BYTE      = 3'd0,
        EV_DONE      = 3'd1,
        EV_EMPTY     = 3'd2,
        EV_VER_ERROR = 3'd3,
        EV_TOO_BIG   = 3'd4
    } event_kind_t;

    // class that the front end gives each byte
    typedef enum logic [1:0] {
        ITEM_OPEN       = 2'd0,
        ITEM_OPEN_SHORT = 2'd1,
        ITEM_BODY       = 2'd2,
        ITEM_BODY_LAST  = 2'd3
    } item_class_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first_of_chunk;
        logic       last_of_chunk;
    } in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  byte_value;
        logic [6:0]  byte_offset;
        logic [15:0] command;
        logic [7:0]  flags;
        logic [1:0]  version;
        logic [7:0]  payload_size;
        logic [7:0]  skip_count;
    } out_t;

    typedef struct packed {
        item_class_t cls;
        logic [7:0]  data;
    } item_t;

endpackage

/* design/mcr_front.sv */
// front end: accepts chunk bytes and classifies them for the queue
module mcr_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mcr_pkg::in_t   s_data,
    output logic           push,
    output mcr_pkg::item_t push_item,
    input  logic           q_full
);

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_item.data = s_data.rx_byte;
        if (s_data.first_of_chunk) begin
            push_item.cls = s_data.last_of_chunk ? mcr_pkg::ITEM_OPEN_SHORT
                                                 : mcr_pkg::ITEM_OPEN;
        end else begin
            push_item.cls = s_data.last_of_chunk ? mcr_pkg::ITEM_BODY_LAST
                                                 : mcr_pkg::ITEM_BODY;
        end
    end

`ifndef ASSERT_OFF
    a_body_first_class: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !s_data.first_of_chunk |->
            (push_item.cls == mcr_pkg::ITEM_BODY || push_item.cls == mcr_pkg::ITEM_BODY_LAST))
        else $error("body byte classified as chunk opener");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("push into full queue");
    a_open_class: assert property (@(posedge aclk) disable iff (!aresetn)
        push && s_data.first_of_chunk |->
            (push_item.cls == mcr_pkg::ITEM_OPEN || push_item.cls == mcr_pkg::ITEM_OPEN_SHORT))
        else $error("chunk opener classified as body byte");
`endif

endmodule

/* design/mcr_queue.sv */
// short fifo of classified bytes between front and back
module mcr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mcr_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output mcr_pkg::item_t q_item
);

    mcr_pkg::item_t mem [mcr_pkg::QUEUE_DEPTH];

    logic [mcr_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mcr_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mcr_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign full    = (count_reg == (mcr_pkg::QUEUE_AW+1)'(mcr_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> !pop)
        else $error("queue underflow");
    a_count_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

/* design/mcr_back.sv */
// back end: chunk state machine, header parse, payload events, output register
module mcr_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [0:0]     cfg_index,
    input  logic [15:0]    cfg_wdata,
    input  logic           q_valid,
    input  mcr_pkg::item_t q_item,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output mcr_pkg::out_t  m_data
);

    logic [15:0] eeprom_cmd_reg;
    logic [7:0]  skip_value_reg;

    mcr_pkg::mode_t mode_reg, mode_next;
    logic        asm_reg, asm_next;
    logic [3:0]  last_seq_reg, last_seq_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] hdr_cmd_reg, hdr_cmd_next;
    logic [7:0]  hdr_flags_reg, hdr_flags_next;
    logic [15:0] hdr_size_reg, hdr_size_next;
    logic [15:0] req_cmd_reg, req_cmd_next;
    logic [7:0]  req_flags_reg, req_flags_next;
    logic [1:0]  req_ver_reg, req_ver_next;
    logic [7:0]  exp_size_reg, exp_size_next;
    logic [7:0]  wr_off_reg, wr_off_next;

    logic                  out_valid_reg, out_valid_next;
    mcr_pkg::out_t         out_reg, out_next;
    logic                  has_res;
    mcr_pkg::event_kind_t  res_kind;
    logic [7:0]            res_val;
    logic [6:0]            res_off;

    assign pop     = q_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // next state for one byte
    always_comb begin
        logic        do_take;
        logic        do_commit;
        logic        commit_v2;
        logic [15:0] commit_size;
        logic [1:0]  ver;
        logic [7:0]  b;
        logic        is_last;

        b           = q_item.data;
        is_last     = (q_item.cls == mcr_pkg::ITEM_BODY_LAST);
        do_take     = 1'b0;
        do_commit   = 1'b0;
        commit_v2   = 1'b0;
        commit_size = hdr_size_reg;
        ver         = held_reg[6:5];

        mode_next      = mode_reg;
        asm_next       = asm_reg;
        last_seq_next  = last_seq_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        hdr_cmd_next   = hdr_cmd_reg;
        hdr_flags_next = hdr_flags_reg;
        hdr_size_next  = hdr_size_reg;
        req_cmd_next   = req_cmd_reg;
        req_flags_next = req_flags_reg;
        req_ver_next   = req_ver_reg;
        exp_size_next  = exp_size_reg;
        wr_off_next    = wr_off_reg;
        has_res        = 1'b0;
        res_kind       = mcr_pkg::EV_BYTE;
        res_val        = '0;
        res_off        = '0;

        if (pop) begin
            case (q_item.cls)
                mcr_pkg::ITEM_OPEN, mcr_pkg::ITEM_OPEN_SHORT: begin
                    held_next = b;
                    idx_next  = '0;
                    mode_next = (q_item.cls == mcr_pkg::ITEM_OPEN_SHORT)
                                ? mcr_pkg::MODE_DISCARD : mcr_pkg::MODE_STATUS;
                end
                default: begin
                    if (mode_reg != mcr_pkg::MODE_DISCARD) begin
                        if (idx_reg != mcr_pkg::INDEX_MAX) begin
                            idx_next = idx_reg + 8'd1;
                        end
                        case (mode_reg)
                            mcr_pkg::MODE_STATUS: begin
                                req_ver_next = ver;
                                if (ver > mcr_pkg::VER_MAX) begin
                                    mode_next = mcr_pkg::MODE_DISCARD;
                                    has_res   = 1'b1;
                                    res_kind  = mcr_pkg::EV_VER_ERROR;
                                end else if (held_reg[4]) begin
                                    if (ver == mcr_pkg::VER_V1) begin
                                        hdr_size_next = {8'h00, b};
                                        mode_next     = mcr_pkg::MODE_HDR_V1;
                                    end else begin
                                        hdr_flags_next = b;
                                        mode_next      = mcr_pkg::MODE_HDR_V2;
                                    end
                                end else if (!asm_reg) begin
                                    mode_next = mcr_pkg::MODE_DISCARD;
                                end else if (last_seq_reg + 4'd1 != held_reg[3:0]) begin
                                    // sequence gap abandons the request
                                    asm_next  = 1'b0;
                                    mode_next = mcr_pkg::MODE_DISCARD;
                                end else begin
                                    last_seq_next = held_reg[3:0];
                                    mode_next     = mcr_pkg::MODE_PAYLOAD;
                                    do_take       = 1'b1;
                                end
                            end
                            mcr_pkg::MODE_HDR_V1: begin
                                hdr_cmd_next = {8'h00, b};
                                if (hdr_size_reg == {8'h00, mcr_pkg::JUMBO_SIZE}) begin
                                    mode_next = mcr_pkg::MODE_HDR_JUMBO;
                                end else begin
                                    do_commit   = 1'b1;
                                    commit_size = hdr_size_reg;
                                end
                            end
                            mcr_pkg::MODE_HDR_JUMBO: begin
                                if (idx_next == 8'd3) begin
                                    hdr_size_next = {8'h00, b};
                                end else begin
                                    hdr_size_next = hdr_size_reg | {b, 8'h00};
                                    do_commit     = 1'b1;
                                    commit_size   = hdr_size_reg | {b, 8'h00};
                                end
                            end
                            mcr_pkg::MODE_HDR_V2: begin
                                if (idx_next == 8'd2) begin
                                    hdr_cmd_next = {8'h00, b};
                                end else if (idx_next == 8'd3) begin
                                    hdr_cmd_next = hdr_cmd_reg | {b, 8'h00};
                                end else if (idx_next == 8'd4) begin
                                    hdr_size_next = {8'h00, b};
                                end else begin
                                    hdr_size_next = hdr_size_reg | {b, 8'h00};
                                    do_commit     = 1'b1;
                                    commit_v2     = 1'b1;
                                    commit_size   = hdr_size_reg | {b, 8'h00};
                                end
                            end
                            mcr_pkg::MODE_PAYLOAD: begin
                                if (!asm_reg) begin
                                    mode_next = mcr_pkg::MODE_DISCARD;
                                end else begin
                                    do_take = 1'b1;
                                end
                            end
                            default: begin
                                mode_next = mcr_pkg::MODE_DISCARD;
                            end
                        endcase

                        if (do_commit) begin
                            req_cmd_next = hdr_cmd_next;
                            if (commit_v2) begin
                                req_flags_next = hdr_flags_reg;
                            end
                            if (commit_size > 16'(mcr_pkg::REQ_BUF_BYTES)) begin
                                mode_next = mcr_pkg::MODE_DISCARD;
                                has_res   = 1'b1;
                                res_kind  = mcr_pkg::EV_TOO_BIG;
                            end else if (commit_size == '0) begin
                                asm_next      = 1'b0;
                                last_seq_next = held_reg[3:0];
                                exp_size_next = '0;
                                wr_off_next   = '0;
                                mode_next     = mcr_pkg::MODE_DISCARD;
                                has_res       = 1'b1;
                                res_kind      = mcr_pkg::EV_EMPTY;
                            end else begin
                                asm_next      = 1'b1;
                                last_seq_next = held_reg[3:0];
                                exp_size_next = commit_size[7:0];
                                wr_off_next   = '0;
                                mode_next     = mcr_pkg::MODE_PAYLOAD;
                            end
                        end

                        if (do_take) begin
                            wr_off_next = wr_off_reg + 8'd1;
                            has_res     = 1'b1;
                            res_val     = b;
                            res_off     = wr_off_reg[6:0];
                            if (wr_off_reg + 8'd1 >= exp_size_reg) begin
                                asm_next  = 1'b0;
                                mode_next = mcr_pkg::MODE_DISCARD;
                                res_kind  = mcr_pkg::EV_DONE;
                            end else begin
                                res_kind  = mcr_pkg::EV_BYTE;
                            end
                        end

                        if (is_last) begin
                            mode_next = mcr_pkg::MODE_DISCARD;
                        end
                    end
                end
            endcase
        end
    end

    // result fields and output register control
    always_comb begin
        logic is_done;
        is_done = (res_kind == mcr_pkg::EV_DONE) || (res_kind == mcr_pkg::EV_EMPTY);

        out_next.event_kind   = res_kind;
        out_next.byte_value   = res_val;
        out_next.byte_offset  = res_off;
        out_next.command      = (res_kind == mcr_pkg::EV_VER_ERROR) ? 16'h0000 : req_cmd_next;
        out_next.flags        = (res_kind == mcr_pkg::EV_VER_ERROR) ? 8'h00 : req_flags_next;
        out_next.version      = req_ver_next;
        out_next.payload_size = (res_kind == mcr_pkg::EV_BYTE || is_done) ? exp_size_next
                                                                        : 8'h00;
        out_next.skip_count   = (is_done && req_cmd_next == eeprom_cmd_reg) ? skip_value_reg
                                                                           : 8'h00;

        out_valid_next = out_valid_reg && !m_ready;
        if (pop && has_res) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && has_res) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eeprom_cmd_reg <= 16'd250;
            skip_value_reg <= 8'd5;
            out_valid_reg  <= 1'b0;
            mode_reg       <= mcr_pkg::MODE_DISCARD;
            asm_reg        <= 1'b0;
            last_seq_reg   <= '0;
            idx_reg        <= '0;
            held_reg       <= '0;
            hdr_cmd_reg    <= '0;
            hdr_flags_reg  <= '0;
            hdr_size_reg   <= '0;
            req_cmd_reg    <= '0;
            req_flags_reg  <= '0;
            req_ver_reg    <= '0;
            exp_size_reg   <= '0;
            wr_off_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (mcr_pkg::cfg_index_t'(cfg_index))
                    mcr_pkg::CFG_EEPROM_WRITE_CMD: eeprom_cmd_reg <= cfg_wdata;
                    mcr_pkg::CFG_SKIP_VALUE:       skip_value_reg <= cfg_wdata[7:0];
                    default:                       eeprom_cmd_reg <= eeprom_cmd_reg;
                endcase
            end
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            asm_reg       <= asm_next;
            last_seq_reg  <= last_seq_next;
            idx_reg       <= idx_next;
            held_reg      <= held_next;
            hdr_cmd_reg   <= hdr_cmd_next;
            hdr_flags_reg <= hdr_flags_next;
            hdr_size_reg  <= hdr_size_next;
            req_cmd_reg   <= req_cmd_next;
            req_flags_reg <= req_flags_next;
            req_ver_reg   <= req_ver_next;
            exp_size_reg  <= exp_size_next;
            wr_off_reg    <= wr_off_next;
        end
    end

`ifndef ASSERT_OFF
    a_payload_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == mcr_pkg::MODE_PAYLOAD |-> asm_reg)
        else $error("payload mode without an open request");
    a_offset_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        asm_reg |-> (wr_off_reg < exp_size_reg))
        else $error("write offset past expected size");
    a_size_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        asm_reg |-> (exp_size_reg != '0 && {8'h00, exp_size_reg} <= 16'(mcr_pkg::REQ_BUF_BYTES)))
        else $error("open request with bad size");
    a_done_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && has_res && res_kind == mcr_pkg::EV_DONE |=> !asm_reg)
        else $error("request still open after completion");
`endif

endmodule

/* design/msp_chunk_reassembler_top.sv */
// top level of the telemetry chunk reassembler
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    mcr_pkg::in_t  (chunk byte, first/last marks)
//   m_        out        m_valid / m_ready    mcr_pkg::out_t (payload byte or request event)
//   cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// one byte per cycle while the queue is not full; the back end state machine takes a byte
// whenever the queue holds one and the output register is empty or being taken; a result
// reaches the output register after its byte has passed through the queue
// a four-entry queue sits between the front classifier and the back state machine
// s_ready drops only when the queue is full: a stalled output holds one result, the queue four bytes
// reset is synchronous on aresetn low; no clearing pass
module msp_chunk_reassembler_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [0:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  mcr_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mcr_pkg::out_t m_data
);

    logic           push;
    mcr_pkg::item_t push_item;
    logic           q_full;
    logic           q_valid;
    mcr_pkg::item_t q_item;
    logic           pop;

    mcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    mcr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    mcr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* sim/msp_chunk_reassembler_top_tb.sv */
// testbench of the chunk reassembler: random chunk streams checked against a byte-wise predictor
class chunk_event_checker;
    localparam int MAX_REPORTS = 40;

    logic [15:0] eeprom_cmd;
    logic [7:0]  skip_value;

    bit              assembling;
    logic [3:0]      last_seq;
    logic [7:0]      chunk_idx;
    mcr_pkg::mode_t  mode;
    logic [7:0]      held_status;
    logic [15:0]     hdr_cmd;
    logic [7:0]      hdr_flags;
    logic [15:0]     hdr_size;
    logic [15:0]     req_cmd;
    logic [7:0]      req_flags;
    logic [1:0]      req_ver;
    logic [15:0]     exp_size;
    logic [15:0]     wr_off;

    mcr_pkg::out_t   expected_events[$];
    int              errors;

    function new();
        eeprom_cmd  = 16'd250;
        skip_value  = 8'd5;
        assembling  = 1'b0;
        last_seq    = '0;
        chunk_idx   = '0;
        mode        = mcr_pkg::MODE_DISCARD;
        held_status = '0;
        hdr_cmd     = '0;
        hdr_flags   = '0;
        hdr_size    = '0;
        req_cmd     = '0;
        req_flags   = '0;
        req_ver     = '0;
        exp_size    = '0;
        wr_off      = '0;
        errors      = 0;
    endfunction

    function void set_register(mcr_pkg::cfg_index_t idx, logic [15:0] value);
        case (idx)
            mcr_pkg::CFG_EEPROM_WRITE_CMD: eeprom_cmd = value;
            mcr_pkg::CFG_SKIP_VALUE:       skip_value = value[7:0];
            default:                       eeprom_cmd = eeprom_cmd;
        endcase
    endfunction

    function int pending();
        return expected_events.size();
    endfunction

    function void emit(mcr_pkg::event_kind_t kind, logic [7:0] value, logic [15:0] offset);
        mcr_pkg::out_t ev;
        bit            completes;
        completes       = (kind == mcr_pkg::EV_DONE) || (kind == mcr_pkg::EV_EMPTY);
        ev.event_kind   = kind;
        ev.byte_value   = value;
        ev.byte_offset  = offset[6:0];
        ev.command      = (kind == mcr_pkg::EV_VER_ERROR) ? 16'd0 : req_cmd;
        ev.flags        = (kind == mcr_pkg::EV_VER_ERROR) ? 8'd0 : req_flags;
        ev.version      = req_ver;
        ev.payload_size = (kind <= mcr_pkg::EV_EMPTY) ? exp_size[7:0] : 8'd0;
        ev.skip_count   = (completes && req_cmd == eeprom_cmd) ? skip_value : 8'd0;
        expected_events.push_back(ev);
    endfunction

    function void commit_header(bit v2);
        req_cmd = hdr_cmd;
        if (v2) begin
            req_flags = hdr_flags;
        end
        if (hdr_size > 16'(mcr_pkg::REQ_BUF_BYTES)) begin
            mode = mcr_pkg::MODE_DISCARD;
            emit(mcr_pkg::EV_TOO_BIG, 8'd0, 16'd0);
            return;
        end
        assembling = 1'b1;
        last_seq   = held_status[3:0];
        exp_size   = hdr_size;
        wr_off     = '0;
        if (exp_size == 16'd0) begin
            assembling = 1'b0;
            mode       = mcr_pkg::MODE_DISCARD;
            emit(mcr_pkg::EV_EMPTY, 8'd0, 16'd0);
            return;
        end
        mode = mcr_pkg::MODE_PAYLOAD;
    endfunction

    function void store_payload(logic [7:0] b);
        logic [15:0] off;
        off = wr_off;
        if (!assembling) begin
            mode = mcr_pkg::MODE_DISCARD;
            return;
        end
        wr_off = wr_off + 16'd1;
        if (wr_off >= exp_size) begin
            assembling = 1'b0;
            mode       = mcr_pkg::MODE_DISCARD;
            emit(mcr_pkg::EV_DONE, b, off);
        end else begin
            emit(mcr_pkg::EV_BYTE, b, off);
        end
    endfunction

    // one accepted chunk byte
    function void take_byte(mcr_pkg::in_t it);
        logic [3:0] seq;
        logic [3:0] next_seq;
        logic [7:0] b;
        b = it.rx_byte;
        if (it.first_of_chunk) begin
            held_status = b;
            chunk_idx   = '0;
            mode        = it.last_of_chunk ? mcr_pkg::MODE_DISCARD : mcr_pkg::MODE_STATUS;
            return;
        end
        if (mode == mcr_pkg::MODE_DISCARD) begin
            return;
        end
        if (chunk_idx != mcr_pkg::INDEX_MAX) begin
            chunk_idx = chunk_idx + 8'd1;
        end
        case (mode)
            mcr_pkg::MODE_STATUS: begin
                seq      = held_status[3:0];
                next_seq = last_seq + 4'd1;
                req_ver  = held_status[6:5];
                if (req_ver > mcr_pkg::VER_MAX) begin
                    mode = mcr_pkg::MODE_DISCARD;
                    emit(mcr_pkg::EV_VER_ERROR, 8'd0, 16'd0);
                end else if (held_status[4]) begin
                    if (req_ver == mcr_pkg::VER_V1) begin
                        hdr_size = {8'h00, b};
                        mode     = mcr_pkg::MODE_HDR_V1;
                    end else begin
                        hdr_flags = b;
                        mode      = mcr_pkg::MODE_HDR_V2;
                    end
                end else if (!assembling) begin
                    mode = mcr_pkg::MODE_DISCARD;
                end else if (next_seq != seq) begin
                    assembling = 1'b0;
                    mode       = mcr_pkg::MODE_DISCARD;
                end else begin
                    last_seq = seq;
                    mode     = mcr_pkg::MODE_PAYLOAD;
                    store_payload(b);
                end
            end
            mcr_pkg::MODE_HDR_V1: begin
                hdr_cmd = {8'h00, b};
                if (hdr_size == {8'h00, mcr_pkg::JUMBO_SIZE}) begin
                    mode = mcr_pkg::MODE_HDR_JUMBO;
                end else begin
                    commit_header(1'b0);
                end
            end
            mcr_pkg::MODE_HDR_JUMBO: begin
                if (chunk_idx == 8'd3) begin
                    hdr_size = {8'h00, b};
                end else begin
                    hdr_size = hdr_size | {b, 8'h00};
                    commit_header(1'b0);
                end
            end
            mcr_pkg::MODE_HDR_V2: begin
                if (chunk_idx == 8'd2) begin
                    hdr_cmd = {8'h00, b};
                end else if (chunk_idx == 8'd3) begin
                    hdr_cmd = hdr_cmd | {b, 8'h00};
                end else if (chunk_idx == 8'd4) begin
                    hdr_size = {8'h00, b};
                end else begin
                    hdr_size = hdr_size | {b, 8'h00};
                    commit_header(1'b1);
                end
            end
            mcr_pkg::MODE_PAYLOAD: store_payload(b);
            default: mode = mcr_pkg::MODE_DISCARD;
        endcase
        if (it.last_of_chunk) begin
            mode = mcr_pkg::MODE_DISCARD;
        end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
        if (errors < MAX_REPORTS) begin
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        errors++;
    endtask

    task check_event(mcr_pkg::out_t got);
        mcr_pkg::out_t want;
        if (expected_events.size() == 0) begin
            report("result transaction with nothing outstanding", got.event_kind, 0);
            return;
        end
        want = expected_events.pop_front();
        if (got.event_kind != want.event_kind)
            report("event_kind", got.event_kind, want.event_kind);
        if (got.byte_value != want.byte_value)
            report("byte_value", got.byte_value, want.byte_value);
        if (got.byte_offset != want.byte_offset)
            report("byte_offset", got.byte_offset, want.byte_offset);
        if (got.command != want.command)
            report("command", got.command, want.command);
        if (got.flags != want.flags)
            report("flags", got.flags, want.flags);
        if (got.version != want.version)
            report("version", got.version, want.version);
        if (got.payload_size != want.payload_size)
            report("payload_size", got.payload_size, want.payload_size);
        if (got.skip_count != want.skip_count)
            report("skip_count", got.skip_count, want.skip_count);
    endtask

    task finish_check();
        if (expected_events.size() != 0)
            report("results never delivered", 0, expected_events.size());
    endtask
endclass

module msp_chunk_reassembler_top_tb;
    localparam int ITEM_TARGET   = 1950;
    localparam int PHASES        = 4;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 150;
    localparam int STALL_LIMIT   = 2000;

    typedef logic [7:0] byte_q_t[$];
    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_style_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [0:0]    cfg_index;
    logic [15:0]   cfg_wdata;
    logic          s_valid;
    logic          s_ready;
    mcr_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    mcr_pkg::out_t m_data;

    chunk_event_checker sb = new();

    int          items_sent = 0;
    int          burst_left = 0;
    int          stalled_cycles = 0;
    bit          hold_output = 1'b0;
    logic [15:0] eeprom_cmd = 16'd250;

    msp_chunk_reassembler_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sends one byte; the sender idles between bursts of random length
    task automatic send_byte(input logic [7:0] b, input logic opens, input logic closes);
        mcr_pkg::in_t it;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 300))
                                                      : int'($urandom_range(1, 20));
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        burst_left--;
        it.rx_byte        = b;
        it.first_of_chunk = opens;
        it.last_of_chunk  = closes;
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_byte(it);
        items_sent++;
    endtask

    task automatic send_chunk(input byte_q_t bytes, input bit close);
        foreach (bytes[i])
            send_byte(bytes[i], i == 0, close && (i == bytes.size() - 1));
    endtask

    // pause until every expected result is out, then let non-producing bytes drain
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_registers(input logic [15:0] cmd, input logic [7:0] skip);
        logic [7:0] upper;
        upper = 8'($urandom);
        cfg_wr_en <= 1'b1;
        cfg_index <= mcr_pkg::CFG_EEPROM_WRITE_CMD;
        cfg_wdata <= cmd;
        @(posedge aclk);
        sb.set_register(mcr_pkg::CFG_EEPROM_WRITE_CMD, cmd);
        cfg_index <= mcr_pkg::CFG_SKIP_VALUE;
        cfg_wdata <= {upper, skip};
        @(posedge aclk);
        sb.set_register(mcr_pkg::CFG_SKIP_VALUE, {upper, skip});
        cfg_wr_en <= 1'b0;
        eeprom_cmd = cmd;
    endtask

    task automatic send_noise();
        int n;
        n = int'($urandom_range(1, 4));
        repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0,
                             $urandom_range(0, 3) == 0);
    endtask

    // one request: header and payload split over chunks, with occasional breakage
    task automatic send_request();
        byte_q_t     msg;
        byte_q_t     chunk;
        logic [1:0]  ver;
        logic [15:0] size;
        logic [15:0] cmd;
        logic [3:0]  seq;
        logic        top_bit;
        logic        start;
        int          pick, hdr_len, pos, body, n;
        bit          short_hdr, whole;
        pick = int'($urandom_range(0, 99));
        ver  = (pick < 40) ? 2'd1 : (pick < 85) ? 2'd2 : (pick < 95) ? 2'd0 : 2'd3;
        pick = int'($urandom_range(0, 99));
        if (pick < 5)       size = 16'd0;
        else if (pick < 75) size = 16'($urandom_range(1, 16));
        else if (pick < 92) size = 16'($urandom_range(17, mcr_pkg::REQ_BUF_BYTES));
        else if (pick < 96) size = 16'(mcr_pkg::REQ_BUF_BYTES);
        else                size = 16'($urandom_range(mcr_pkg::REQ_BUF_BYTES + 1, 65535));
        cmd = ($urandom_range(0, 3) == 0) ? eeprom_cmd : 16'($urandom);
        if (ver == mcr_pkg::VER_V1) begin
            if (size > 16'd254 || $urandom_range(0, 4) == 0) begin
                msg.push_back(mcr_pkg::JUMBO_SIZE);
                msg.push_back(cmd[7:0]);
                msg.push_back(size[7:0]);
                msg.push_back(size[15:8]);
            end else begin
                msg.push_back(size[7:0]);
                msg.push_back(cmd[7:0]);
            end
        end else begin
            msg.push_back(8'($urandom));
            msg.push_back(cmd[7:0]);
            msg.push_back(cmd[15:8]);
            msg.push_back(size[7:0]);
            msg.push_back(size[15:8]);
        end
        hdr_len = msg.size();
        n = (size <= 16'(mcr_pkg::REQ_BUF_BYTES)) ? int'(size) : int'($urandom_range(0, 4));
        repeat (n) msg.push_back(8'($urandom));
        // surplus bytes, now and then enough to run the chunk index to its limit
        pick = int'($urandom_range(0, 49));
        if (pick == 0)     n = int'($urandom_range(120, 200));
        else if (pick < 8) n = int'($urandom_range(1, 3));
        else               n = 0;
        repeat (n) msg.push_back(8'($urandom));
        short_hdr = ($urandom_range(0, 24) == 0);
        whole     = ($urandom_range(0, 9) == 0);
        seq   = 4'($urandom);
        start = 1'b1;
        pos   = 0;
        while (pos < msg.size()) begin
            chunk.delete();
            top_bit = 1'($urandom_range(0, 1));
            chunk.push_back({top_bit, ver, start, seq});
            if (start && short_hdr)
                body = int'($urandom_range(1, hdr_len - 1));
            else if (whole)
                body = msg.size();
            else if (start)
                body = hdr_len + int'($urandom_range(0, 12));
            else
                body = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 60))
                                                   : int'($urandom_range(1, 12));
            while (body > 0 && pos < msg.size()) begin
                chunk.push_back(msg[pos]);
                pos++;
                body--;
            end
            // an open chunk gets cut off by the next first mark
            send_chunk(chunk, $urandom_range(0, 29) != 0);
            start = 1'b0;
            seq   = seq + (($urandom_range(0, 29) == 0) ? 4'd2 : 4'd1);
        end
    endtask

    initial begin
        logic [15:0] cmd;
        logic [7:0]  skip;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= mcr_pkg::CFG_EEPROM_WRITE_CMD;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_registers(16'h00fa, 8'h5a);

        // v1 request of two bytes over two chunks, command matches the eeprom write
        send_chunk('{8'h30, 8'h02, 8'hfa, 8'hff}, 1'b1);
        send_chunk('{8'h01, 8'h00}, 1'b1);
        // one-byte chunk
        send_chunk('{8'h7f}, 1'b1);
        // version three
        send_chunk('{8'h6f, 8'h00}, 1'b1);
        // v2 request of size zero
        send_chunk('{8'h52, 8'ha5, 8'h34, 8'h12, 8'h00, 8'h00}, 1'b1);
        // v1 jumbo asking for more than the buffer holds
        send_chunk('{8'h33, 8'hff, 8'h07, 8'h81, 8'h00}, 1'b1);
        // start chunk that ends inside its header
        send_chunk('{8'h14, 8'h03}, 1'b1);
        // stray byte with no chunk open
        send_byte(8'h99, 1'b0, 1'b0);
        // request left open, then a continuation that skips a sequence number
        send_chunk('{8'h30, 8'h03, 8'h09}, 1'b1);
        send_chunk('{8'h05, 8'h77}, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin cmd = 16'h0000; skip = 8'h00; end
                1: begin cmd = 16'hffff; skip = 8'hff; end
                2: begin cmd = 16'($urandom_range(0, 255)); skip = 8'($urandom); end
                default: begin cmd = 16'($urandom); skip = 8'($urandom); end
            endcase
            set_registers(cmd, skip);
            if (p % 2 == 1)
                hold_output = 1'b1;
            while (items_sent < ITEM_TARGET * (p + 1) / PHASES) begin
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                send_request();
            end
        end

        drain();
        sb.finish_check();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: changes its stall pattern now and then, and holds off on request
    initial begin
        rx_style_t style;
        int        left;
        int        tick;
        m_ready <= 1'b0;
        style = RX_ALWAYS;
        left  = 0;
        tick  = 0;
        forever begin
            @(posedge aclk);
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end else begin
                if (left == 0) begin
                    style = rx_style_t'($urandom_range(0, 3));
                    left  = int'($urandom_range(30, 300));
                end
                left--;
                tick++;
                case (style)
                    RX_ALWAYS:  m_ready <= 1'b1;
                    RX_MOSTLY:  m_ready <= ($urandom_range(0, 99) < 70);
                    RX_RARELY:  m_ready <= ($urandom_range(0, 99) < 20);
                    default:    m_ready <= ((tick % 7) >= 3);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_event(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end
endmodule

/* filelist.f */
design/mcr_pkg.sv
design/mcr_front.sv
design/mcr_queue.sv
design/mcr_back.sv
design/msp_chunk_reassembler_top.sv
sim/msp_chunk_reassembler_top_tb.sv
